// ===== hw/rtl/pow2_size_class_free_list_pool_core_defines.svh =====
// Assertion macros shared by the pool RTL.
// Each expects clk and arst_n in scope.
`ifndef POW2_SIZE_CLASS_FREE_LIST_POOL_CORE_DEFINES_SVH
`define POW2_SIZE_CLASS_FREE_LIST_POOL_CORE_DEFINES_SVH

// Same-cycle implication.
`define P2FL_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define P2FL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/p2fl_pkg.sv =====
package p2fl_pkg;

	localparam int ADDR_BITS   = 48;
	localparam int NUM_CLASSES = 49;
	localparam int STACK_DEPTH = 64;

	localparam int SIZE_W    = 49;
	localparam int OADDR_W   = 48;
	localparam int CLASS_W   = 6;
	localparam int CIDX_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
	localparam int SLOT_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int STK_ENTRIES = NUM_CLASSES * STACK_DEPTH;
	localparam int STK_AW    = (STK_ENTRIES > 1) ? $clog2(STK_ENTRIES) : 1;

	localparam logic [1:0] ST_REUSED  = 2'd0;
	localparam logic [1:0] ST_FRESH   = 2'd1;
	localparam logic [1:0] ST_STORED  = 2'd2;
	localparam logic [1:0] ST_DROPPED = 2'd3;

	typedef struct packed {
		logic                 fill_rd_en;
		logic [CIDX_W-1:0]    fill_rd_idx;
		logic                 fill_wr_en;
		logic [CIDX_W-1:0]    fill_wr_idx;
		logic [FILL_W-1:0]    fill_wr_data;
		logic                 stk_rd_en;
		logic                 stk_wr_en;
		logic [STK_AW-1:0]    stk_idx;
		logic [ADDR_BITS-1:0] stk_wr_data;
	} p2fl_store_req_t;

	// Flat stack address: class row times depth plus slot.
	function automatic logic [STK_AW-1:0] stk_index(logic [CIDX_W-1:0] cls,
			logic [SLOT_W-1:0] slot);
		return STK_AW'(STK_AW'(cls) * STK_AW'(STACK_DEPTH)) + STK_AW'(slot);
	endfunction

endpackage

// ===== hw/rtl/p2fl_store.sv =====
module p2fl_store
	import p2fl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  p2fl_store_req_t      req,
	output logic [FILL_W-1:0]    fill_rd,
	output logic [ADDR_BITS-1:0] stk_rd
);

	logic [FILL_W-1:0]    fill_mem [NUM_CLASSES];
	logic [ADDR_BITS-1:0] stk_mem [STK_ENTRIES];
	logic [NUM_CLASSES-1:0] fill_vld_q;
	logic                 fill_hit_q;
	logic [FILL_W-1:0]    fill_rd_q;
	logic [ADDR_BITS-1:0] stk_rd_q;

	always_ff @(posedge clk) begin
		if (req.fill_wr_en) begin
			fill_mem[req.fill_wr_idx] <= req.fill_wr_data;
		end
		if (req.fill_rd_en) begin
			fill_rd_q <= fill_mem[req.fill_rd_idx];
		end
	end

	// Counts never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q <= '0;
			fill_hit_q <= 1'b0;
		end else begin
			if (req.fill_wr_en) begin
				fill_vld_q[req.fill_wr_idx] <= 1'b1;
			end
			if (req.fill_rd_en) begin
				fill_hit_q <= fill_vld_q[req.fill_rd_idx];
			end
		end
	end

	assign fill_rd = fill_hit_q ? fill_rd_q : '0;

	always_ff @(posedge clk) begin
		if (req.stk_wr_en) begin
			stk_mem[req.stk_idx] <= req.stk_wr_data;
		end
		if (req.stk_rd_en) begin
			stk_rd_q <= stk_mem[req.stk_idx];
		end
	end

	assign stk_rd = stk_rd_q;

endmodule

// ===== hw/rtl/pow2_size_class_free_list_pool_core.sv =====
// Free-list pool with one LIFO stack of block addresses per power-of-two size class.
// Input channel (in_valid/in_ready): kind, req_size, block_addr. kind 0 allocates,
// kind 1 releases block_addr. Output channel (out_valid/out_ready): status, out_addr,
// size_class, one result beat per input beat, in order.
// Each request walks a small sequencer: class decode, then a read of the class fill
// count memory, then for a successful allocate a read of the address stack memory.
// Release, fresh and drop results are loaded into the output register from the fill
// step; a reuse (pop) result is loaded from a further stack-read step. A new request
// is not taken until the previous one leaves the sequencer, as the reads are serial.
// A new request is accepted as soon as the sequencer is back idle, even while the
// previous result sits in the output register.
// If out_ready is low while the output register is full when a result is due, the
// sequencer holds in its last step (a release before its memory update, a pop after it,
// with the read data kept) and in_ready stays low until the output register frees up.
// Reset clears all class fill counts (per-class valid flags, no clearing pass) and
// the sequencer; stack contents are only ever read below the fill count.
`include "pow2_size_class_free_list_pool_core_defines.svh"

module pow2_size_class_free_list_pool_core
	import p2fl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [SIZE_W-1:0]  req_size,
	input  logic [OADDR_W-1:0] block_addr,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [OADDR_W-1:0] out_addr,
	output logic [CLASS_W-1:0] size_class
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CLASS = 4'b0010,
		S_FILL  = 4'b0100,
		S_POP   = 4'b1000
	} state_t;

	state_t               state_q, state_d;
	logic                 kind_q;
	logic [SIZE_W-1:0]    size_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [CLASS_W-1:0]   class_q;
	logic                 range_q;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [OADDR_W-1:0]   out_addr_q;
	logic [CLASS_W-1:0]   size_class_q;

	logic [CLASS_W-1:0]   cls;
	logic                 cls_range;
	logic [SIZE_W-1:0]    size_m1;

	p2fl_store_req_t      sreq;
	logic [FILL_W-1:0]    fill_rd;
	logic [ADDR_BITS-1:0] stk_rd;

	logic                 out_free;
	logic                 in_acc;
	logic                 load;
	logic [1:0]           load_status;
	logic [OADDR_W-1:0]   load_addr;
	logic                 fill_full;
	logic                 fill_empty;
	logic [CIDX_W-1:0]    cidx;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// Ceiling log2: bit length of size - 1, zero for sizes 0 and 1.
	always_comb begin
		size_m1 = size_q - SIZE_W'(1);
		cls     = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (size_m1[i]) begin
				cls = CLASS_W'(i + 1);
			end
		end
		if (size_q <= SIZE_W'(1)) begin
			cls = '0;
		end
	end

	assign cls_range  = ({1'b0, cls} < (CLASS_W + 1)'(NUM_CLASSES));
	assign cidx       = CIDX_W'(class_q);
	assign fill_full  = (fill_rd >= FILL_W'(STACK_DEPTH));
	assign fill_empty = (fill_rd == '0);

	always_comb begin
		state_d      = state_q;
		sreq         = '0;
		load         = 1'b0;
		load_status  = ST_FRESH;
		load_addr    = '0;
		sreq.fill_rd_idx  = CIDX_W'(cls);
		sreq.fill_wr_idx  = cidx;
		sreq.stk_wr_data  = addr_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_CLASS;
				end
			end
			S_CLASS: begin
				sreq.fill_rd_en = cls_range;
				state_d         = S_FILL;
			end
			S_FILL: begin
				if (!kind_q && range_q && !fill_empty) begin
					// pop: count update now, stack data next cycle
					sreq.stk_rd_en    = 1'b1;
					sreq.stk_idx      = stk_index(cidx, SLOT_W'(fill_rd - FILL_W'(1)));
					sreq.fill_wr_en   = 1'b1;
					sreq.fill_wr_data = fill_rd - FILL_W'(1);
					state_d           = S_POP;
				end else if (out_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
					if (kind_q && range_q && !fill_full) begin
						sreq.stk_wr_en    = 1'b1;
						sreq.stk_idx      = stk_index(cidx, SLOT_W'(fill_rd));
						sreq.fill_wr_en   = 1'b1;
						sreq.fill_wr_data = fill_rd + FILL_W'(1);
						load_status       = ST_STORED;
					end else begin
						load_status = kind_q ? ST_DROPPED : ST_FRESH;
					end
				end
			end
			S_POP: begin
				if (out_free) begin
					load        = 1'b1;
					load_status = ST_REUSED;
					load_addr   = OADDR_W'(stk_rd);
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	p2fl_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (sreq),
		.fill_rd (fill_rd),
		.stk_rd  (stk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= kind;
			size_q <= req_size;
			addr_q <= ADDR_BITS'(block_addr);
		end
		if (state_q == S_CLASS) begin
			class_q <= cls;
			range_q <= cls_range;
		end
		if (load) begin
			status_q     <= load_status;
			out_addr_q   <= load_addr;
			size_class_q <= class_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_addr   = out_addr_q;
	assign size_class = size_class_q;

	`P2FL_ASSERT(a_state_onehot, 1'b1, $onehot(state_q), "sequencer state not one-hot")
	`P2FL_ASSERT_NEXT(a_accept_decode, in_acc, state_q == S_CLASS,
		"accepted beat did not enter class decode")
	`P2FL_ASSERT(a_fill_bound, sreq.fill_wr_en, sreq.fill_wr_data <= FILL_W'(STACK_DEPTH),
		"fill count beyond stack depth")
	`P2FL_ASSERT(a_stk_one_port, sreq.stk_wr_en, !sreq.stk_rd_en,
		"stack read and write in one cycle")
	`P2FL_ASSERT(a_addr_zero, out_valid_q && (status_q != ST_REUSED), out_addr_q == '0,
		"nonzero address on a non-reuse result")

endmodule
